### rtl/x86_64_instruction_encoder_top_macros.svh
// Assertion macros for the x86-64 instruction encoder.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef X86_64_INSTRUCTION_ENCODER_TOP_MACROS_SVH
`define X86_64_INSTRUCTION_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define XIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define XIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define XIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define XIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/xie_pkg.sv
// Shared types and constants for the x86-64 instruction encoder.
// No dependencies; imported by the front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none

package xie_pkg;

  localparam int MAX_BYTES = 10;   // longest encoding: mov imm64
  localparam int CNT_W     = 4;    // holds 0..MAX_BYTES

  // One classified instruction, ready for serialization.
  typedef struct packed {
    logic                        restart;
    logic                        is_label;
    logic [CNT_W-1:0]            count;   // bytes to emit, 0 for unknown forms
    logic [MAX_BYTES-1:0][7:0]   bytes;   // byte 0 goes out first
  } xie_desc_t;

endpackage

`default_nettype wire

### rtl/xie_front.sv
// Front end: accepts input transactions and encodes them into byte descriptors.
// Depends on xie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xie_front
  import xie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // restart, dest_reg[3:0], src_reg[3:0], value[63:0], pad
  input  wire logic [4:0]  in_tuser,   // opcode
  output logic             desc_valid,
  input  wire logic        desc_ready,
  output xie_desc_t        desc
);

  localparam logic [4:0] OP_LABEL    = 5'd0;
  localparam logic [4:0] OP_LEA      = 5'd1;
  localparam logic [4:0] OP_STORE    = 5'd2;
  localparam logic [4:0] OP_JMP_REL  = 5'd3;
  localparam logic [4:0] OP_LOAD     = 5'd4;
  localparam logic [4:0] OP_PUSH     = 5'd5;
  localparam logic [4:0] OP_MOV_RR   = 5'd6;
  localparam logic [4:0] OP_SUB_IMM  = 5'd7;
  localparam logic [4:0] OP_ADD_IMM  = 5'd8;
  localparam logic [4:0] OP_POP      = 5'd9;
  localparam logic [4:0] OP_LEAVE    = 5'd10;
  localparam logic [4:0] OP_RET      = 5'd11;
  localparam logic [4:0] OP_JMP_REG  = 5'd12;
  localparam logic [4:0] OP_JE_REL   = 5'd13;
  localparam logic [4:0] OP_OR_RR    = 5'd14;
  localparam logic [4:0] OP_MOV_IMM  = 5'd15;
  localparam logic [4:0] OP_CALL_REG = 5'd16;

  localparam logic [7:0] BYTE_LEA     = 8'h8D;
  localparam logic [7:0] BYTE_STORE   = 8'h89;
  localparam logic [7:0] BYTE_JMP     = 8'hE9;
  localparam logic [7:0] BYTE_LOAD    = 8'h8B;
  localparam logic [7:0] BYTE_PUSH    = 8'h50;
  localparam logic [7:0] BYTE_ALU_IMM = 8'h81;
  localparam logic [7:0] BYTE_POP     = 8'h58;
  localparam logic [7:0] BYTE_LEAVE   = 8'hC9;
  localparam logic [7:0] BYTE_RET     = 8'hC3;
  localparam logic [7:0] BYTE_GRP5    = 8'hFF;
  localparam logic [7:0] BYTE_JE      = 8'h84;
  localparam logic [7:0] BYTE_MOV_IMM = 8'hB8;
  localparam logic [7:0] BYTE_TWO_OP  = 8'h0F;
  localparam logic [7:0] BYTE_OR      = 8'h0B;
  localparam logic [7:0] REX_BASE     = 8'h40;
  localparam logic [7:0] REX_W        = 8'h48;
  localparam logic [7:0] REX_B        = 8'h41;
  localparam logic [7:0] SIB_NO_INDEX = 8'h24;

  logic        f_valid_r;
  xie_desc_t   f_desc_r;
  xie_desc_t   f_desc_nxt;

  logic        restart;
  logic [3:0]  dst;
  logic [3:0]  src;
  logic [7:0][7:0] val_bytes;

  assign restart   = in_tdata[0];
  assign dst       = in_tdata[4:1];
  assign src       = in_tdata[8:5];
  assign val_bytes = in_tdata[72:9];

  // Encoding: a header of up to four bytes, then a little-endian literal.
  always_comb begin
    logic [3:0][7:0] hdr;
    logic [2:0]      hdr_len;
    logic [3:0]      imm_len;
    logic            rex_form;
    logic            short_form;
    logic [7:0]      opc;
    logic [3:0]      reg_f;
    logic [3:0]      rm_f;
    logic            mem;
    logic            wide;
    logic            label;
    logic [3:0]      kk;
    logic [3:0]      sel;

    hdr        = '0;
    hdr_len    = 3'd0;
    imm_len    = 4'd0;
    rex_form   = 1'b0;
    short_form = 1'b0;
    opc        = 8'h00;
    reg_f      = 4'd0;
    rm_f       = 4'd0;
    mem        = 1'b0;
    wide       = 1'b1;
    label      = 1'b0;
    kk         = 4'd0;
    sel        = 4'd0;

    unique case (in_tuser)
      OP_LABEL:    label = 1'b1;
      OP_LEA: begin
        rex_form = 1'b1; opc = BYTE_LEA; reg_f = dst; rm_f = src; mem = 1'b1; imm_len = 4'd4;
      end
      OP_STORE: begin
        rex_form = 1'b1; opc = BYTE_STORE; reg_f = src; rm_f = dst; mem = 1'b1; imm_len = 4'd4;
      end
      OP_JMP_REL: begin
        hdr[0] = BYTE_JMP; hdr_len = 3'd1; imm_len = 4'd4;
      end
      OP_LOAD: begin
        rex_form = 1'b1; opc = BYTE_LOAD; reg_f = dst; rm_f = src; mem = 1'b1; imm_len = 4'd4;
      end
      OP_PUSH: begin
        short_form = 1'b1; opc = BYTE_PUSH;
      end
      OP_MOV_RR: begin
        rex_form = 1'b1; opc = BYTE_LOAD; reg_f = dst; rm_f = src;
      end
      OP_SUB_IMM: begin
        rex_form = 1'b1; opc = BYTE_ALU_IMM; reg_f = 4'd5; rm_f = dst; imm_len = 4'd4;
      end
      OP_ADD_IMM: begin
        rex_form = 1'b1; opc = BYTE_ALU_IMM; reg_f = 4'd0; rm_f = dst; imm_len = 4'd4;
      end
      OP_POP: begin
        short_form = 1'b1; opc = BYTE_POP;
      end
      OP_LEAVE: begin
        hdr[0] = BYTE_LEAVE; hdr_len = 3'd1;
      end
      OP_RET: begin
        hdr[0] = BYTE_RET; hdr_len = 3'd1;
      end
      OP_JMP_REG: begin
        rex_form = 1'b1; opc = BYTE_GRP5; reg_f = 4'd4; rm_f = dst; wide = 1'b0;
      end
      OP_JE_REL: begin
        hdr[0] = BYTE_TWO_OP; hdr[1] = BYTE_JE; hdr_len = 3'd2; imm_len = 4'd4;
      end
      OP_OR_RR: begin
        rex_form = 1'b1; opc = BYTE_OR; reg_f = dst; rm_f = src;
      end
      OP_MOV_IMM: begin
        hdr[0]  = REX_W | {7'd0, dst[3]};
        hdr[1]  = BYTE_MOV_IMM | {5'd0, dst[2:0]};
        hdr_len = 3'd2;
        imm_len = 4'd8;
      end
      OP_CALL_REG: begin
        rex_form = 1'b1; opc = BYTE_GRP5; reg_f = 4'd2; rm_f = dst; wide = 1'b0;
      end
      default: ;   // unknown form: no bytes, restart still travels
    endcase

    if (rex_form) begin
      hdr[0]  = REX_BASE | {4'd0, wide, reg_f[3], 1'b0, rm_f[3]};
      hdr[1]  = opc;
      hdr[2]  = {(mem ? 2'b10 : 2'b11), reg_f[2:0], rm_f[2:0]};
      hdr[3]  = SIB_NO_INDEX;
      // rsp / r12 as a base needs a SIB byte
      hdr_len = (mem && (rm_f[2:0] == 3'd4)) ? 3'd4 : 3'd3;
    end else if (short_form) begin
      if (dst[3]) begin
        hdr[0]  = REX_B;
        hdr[1]  = opc | {5'd0, dst[2:0]};
        hdr_len = 3'd2;
      end else begin
        hdr[0]  = opc | {5'd0, dst[2:0]};
        hdr_len = 3'd1;
      end
    end

    f_desc_nxt.restart  = restart;
    f_desc_nxt.is_label = label;
    f_desc_nxt.count    = label ? CNT_W'(1) : ({1'b0, hdr_len} + imm_len);
    for (int k = 0; k < MAX_BYTES; k++) begin
      kk  = 4'(k);
      sel = kk - {1'b0, hdr_len};
      if (label) begin
        f_desc_nxt.bytes[k] = 8'h00;
      end else if (kk < {1'b0, hdr_len}) begin
        f_desc_nxt.bytes[k] = hdr[kk[1:0]];
      end else begin
        f_desc_nxt.bytes[k] = val_bytes[sel[2:0]];
      end
    end
  end

  assign in_tready  = !f_valid_r || desc_ready;
  assign desc_valid = f_valid_r;
  assign desc       = f_desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_tready) begin
      f_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      f_desc_r <= f_desc_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/xie_queue.sv
// Short descriptor queue between the encoding front end and the byte back end.
// Depends on xie_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "x86_64_instruction_encoder_top_macros.svh"

module xie_queue
  import xie_pkg::*;
#(
  parameter int DEPTH = 2   // 2..16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire xie_desc_t wr_desc,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output xie_desc_t      rd_desc
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  xie_desc_t      entry_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_desc  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

  `XIE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= FULL_CNT, "queue count over depth")
  `XIE_ASSERT_IMP(a_ptr_match, clk, rst_n, (cnt_r == '0) || (cnt_r == FULL_CNT), wr_ptr_r == rd_ptr_r, "queue pointers disagree with count")
  `XIE_ASSERT_NXT(a_cnt_hold, clk, rst_n, push && pop, $stable(cnt_r), "queue count moved on push with pop")

endmodule

`default_nettype wire

### rtl/xie_back.sv
// Back end: serializes queued descriptors into byte results and keeps the offset.
// Depends on xie_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "x86_64_instruction_encoder_top_macros.svh"

module xie_back
  import xie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        desc_valid,
  output logic             desc_ready,
  input  wire xie_desc_t   desc,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // out_byte[7:0], out_offset[31:0]
  output logic             out_tuser,   // is_label
  output logic             out_tlast    // is_last
);

  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic [31:0]      off_r;
  logic [31:0]      off_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       byte_r;
  logic [31:0]      offset_r;
  logic             label_r;
  logic             last_r;

  logic             adv;
  logic             no_bytes;
  logic             load;
  logic             last_one;
  logic [31:0]      cur_off;
  logic [31:0]      cur_off_inc;

  assign adv         = !out_valid_r || out_tready;
  assign no_bytes    = !desc.is_label && (desc.count == '0);
  assign load        = desc_valid && !no_bytes && adv;
  assign last_one    = desc.is_label || (idx_r == desc.count - CNT_W'(1));
  // restart applies once, before the first result of the instruction
  assign cur_off     = ((idx_r == '0) && desc.restart) ? 32'd0 : off_r;
  assign cur_off_inc = cur_off + 32'd1;
  assign desc_ready  = desc_valid && (no_bytes || (adv && last_one));

  always_comb begin
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (desc_valid && no_bytes) begin
      off_nxt = cur_off;
      idx_nxt = '0;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      off_nxt       = desc.is_label ? cur_off : cur_off_inc;
      idx_nxt       = last_one ? '0 : idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= desc.bytes[idx_r];
      offset_r <= cur_off;
      label_r  <= desc.is_label;
      last_r   <= last_one;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {offset_r, byte_r};
  assign out_tuser  = label_r;
  assign out_tlast  = last_r;

  `XIE_ASSERT_IMP(a_idx_range, clk, rst_n, desc_valid && !no_bytes && !desc.is_label, idx_r < desc.count, "byte index past instruction length")
  `XIE_ASSERT_NXT(a_off_step, clk, rst_n, load && !desc.is_label, off_r == $past(cur_off_inc), "offset did not advance by one byte")
  `XIE_ASSERT_IMP(a_label_last, clk, rst_n, out_valid_r && label_r, last_r && (byte_r == 8'h00), "label marker must be a lone zero result")

endmodule

`default_nettype wire

### rtl/x86_64_instruction_encoder_top.sv
// Top level of the x86-64 instruction encoder: front end, queue and back end.
// Depends on xie_pkg, xie_front, xie_queue, xie_back.
//
//   channel | dir | tdata                                       | tuser    | tlast
//   in_     | in  | restart, dest_reg, src_reg, value (80 bits) | opcode   | -
//   out_    | out | out_byte, out_offset (40 bits)              | is_label | is_last
//
// The back end emits one result per cycle from a single byte-wide output register
// while out_tready is high; an instruction of N bytes (1 to 10) gives N results, a
// label one, and an unknown opcode is consumed with no result.
// The front end encodes one transaction per cycle into a one-entry stage; the queue
// between front and back absorbs bursts so input keeps flowing while bytes drain.
// Reset (rst_n low, synchronous) clears the offset, queue and all valid flags.
// A stall on out_tready holds the current result; input stalls only when the
// front stage and the queue are both full.
`timescale 1ns / 1ps
`default_nettype none

module x86_64_instruction_encoder_top
  import xie_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2   // descriptor queue entries, 2..16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // restart[0], dest_reg[4:1], src_reg[8:5],
                                       // value[72:9], zero pad[79:73]
  input  wire logic [4:0]  in_tuser,   // opcode
  // result transactions
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // out_byte[7:0], out_offset[39:8]
  output logic             out_tuser,  // is_label
  output logic             out_tlast   // is_last
);

  // front end -> queue
  logic      fq_valid;
  logic      fq_ready;
  xie_desc_t fq_desc;

  // queue -> back end
  logic      qb_valid;
  logic      qb_ready;
  xie_desc_t qb_desc;

  xie_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .desc_valid (fq_valid),
    .desc_ready (fq_ready),
    .desc       (fq_desc)
  );

  xie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_desc  (fq_desc),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_desc  (qb_desc)
  );

  // back end keeps the running byte offset and owns the output register
  xie_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (qb_valid),
    .desc_ready (qb_ready),
    .desc       (qb_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### dv/tb_x86_64_instruction_encoder_top.sv
// Self-checking testbench for x86_64_instruction_encoder_top: byte-accurate encoding
// predictor, bursty sender and stalling receiver on the stream channels.
// Depends on the RTL only (xie_pkg, x86_64_instruction_encoder_top and its submodules).
`timescale 1ns / 1ps

module tb_x86_64_instruction_encoder_top;

  // Instruction forms carried on in_tuser. Everything from OP_UNUSED_LO up is
  // undefined and must vanish without a result.
  typedef enum logic [4:0] {
    OP_LABEL     = 5'd0,
    OP_LEA       = 5'd1,
    OP_STORE     = 5'd2,
    OP_JMP_REL   = 5'd3,
    OP_LOAD      = 5'd4,
    OP_PUSH      = 5'd5,
    OP_MOV_RR    = 5'd6,
    OP_SUB_IMM   = 5'd7,
    OP_ADD_IMM   = 5'd8,
    OP_POP       = 5'd9,
    OP_LEAVE     = 5'd10,
    OP_RET       = 5'd11,
    OP_JMP_REG   = 5'd12,
    OP_JE_REL    = 5'd13,
    OP_OR_RR     = 5'd14,
    OP_MOV_IMM64 = 5'd15,
    OP_CALL_REG  = 5'd16,
    OP_UNUSED_LO = 5'd17,
    OP_UNUSED_HI = 5'd31
  } instr_op_e;

  // Machine-code bytes and fixed ModRM reg-field extensions.
  localparam logic [7:0] X86_REX      = 8'h40;
  localparam logic [7:0] X86_REX_B    = 8'h41;
  localparam logic [7:0] X86_REX_W    = 8'h48;
  localparam logic [7:0] X86_SIB_NONE = 8'h24;  // no index, scale 1, base rsp/r12
  localparam logic [7:0] X86_LEA      = 8'h8D;
  localparam logic [7:0] X86_MOV_ST   = 8'h89;
  localparam logic [7:0] X86_MOV_LD   = 8'h8B;
  localparam logic [7:0] X86_JMP_REL  = 8'hE9;
  localparam logic [7:0] X86_PUSH     = 8'h50;
  localparam logic [7:0] X86_POP      = 8'h58;
  localparam logic [7:0] X86_GRP1_IMM = 8'h81;
  localparam logic [7:0] X86_LEAVE    = 8'hC9;
  localparam logic [7:0] X86_RET      = 8'hC3;
  localparam logic [7:0] X86_GRP5     = 8'hFF;
  localparam logic [7:0] X86_ESC_0F   = 8'h0F;
  localparam logic [7:0] X86_JE_REL   = 8'h84;
  localparam logic [7:0] X86_OR_RR    = 8'h0B;
  localparam logic [7:0] X86_MOV_IMM  = 8'hB8;
  localparam logic [3:0] EXT_ADD      = 4'd0;
  localparam logic [3:0] EXT_CALL     = 4'd2;
  localparam logic [3:0] EXT_JMP      = 4'd4;
  localparam logic [3:0] EXT_SUB      = 4'd5;

  localparam int CLK_HALF     = 5;
  localparam int RST_CYCLES   = 7;
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;   // receiver hold-off, cycles
  localparam int HOLD_AFTER   = 60;    // accepted transactions before the hold-off
  localparam int DRAIN_CYCLES = 20;    // tail after the last expected result

  // Receiver ready patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS, RX_MOSTLY, RX_EVERY_4TH_LOW, RX_COIN
  } rx_mode_e;

  // One input transaction; quiesce marks a point where the sender waits for all
  // expected bytes before it offers the next item.
  typedef struct packed {
    logic        quiesce;
    logic        restart;
    logic [4:0]  opcode;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [63:0] value;
  } instr_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  code_byte;
    logic [31:0] offset;
    logic        is_label;
    logic        is_last;
  } emit_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic [4:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  instr_t      instr_pending[$];   // not yet offered
  emit_t       bytes_expected[$];  // predicted results, oldest first
  logic [7:0]  enc_bytes[$];       // scratch for the encoding of one instruction
  logic [31:0] code_offset;        // predicted running byte offset
  instr_t      cur_instr;          // item on the input bus
  int          mismatch_cnt = 0;
  int          in_accepted  = 0;
  int          gap_left     = 0;
  int          burst_left   = 1;
  bit          rcv_hold     = 1'b0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;
  rx_mode_e    rx_mode      = RX_ALWAYS;
  int          rx_phase     = 0;
  int          cycle_cnt    = 0;

  x86_64_instruction_encoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // ------------------------------------------------------------------------
  // Encoding predictor
  // ------------------------------------------------------------------------

  // REX + opcode + ModRM (+ SIB when the memory base is rsp or r12).
  function automatic void put_rex_modrm(logic [7:0] op, logic [3:0] modrm_reg,
                                        logic [3:0] rm, bit mem, bit wide);
    enc_bytes.push_back(X86_REX | {4'b0, wide, modrm_reg[3], 1'b0, rm[3]});
    enc_bytes.push_back(op);
    enc_bytes.push_back({(mem ? 2'b10 : 2'b11), modrm_reg[2:0], rm[2:0]});
    if (mem && rm[2:0] == 3'd4)
      enc_bytes.push_back(X86_SIB_NONE);
  endfunction

  function automatic void put_le(logic [63:0] v, int count);
    for (int i = 0; i < count; i++)
      enc_bytes.push_back(v[8*i +: 8]);
  endfunction

  // push/pop: REX.B only for r8..r15, register folded into the opcode
  function automatic void put_short_reg(logic [7:0] base, logic [3:0] r);
    if (r[3])
      enc_bytes.push_back(X86_REX_B);
    enc_bytes.push_back(base + {5'b0, r[2:0]});
  endfunction

  // Advance the predicted offset and queue the expected results of one item.
  function automatic void predict_encoding(instr_t it);
    emit_t e;
    enc_bytes.delete();
    if (it.restart)
      code_offset = '0;
    case (it.opcode)
      OP_LABEL: begin
        e = '{code_byte: 8'h00, offset: code_offset, is_label: 1'b1, is_last: 1'b1};
        bytes_expected.push_back(e);
      end
      OP_LEA: begin
        put_rex_modrm(X86_LEA, it.dst, it.src, 1'b1, 1'b1);
        put_le(it.value, 4);
      end
      OP_STORE: begin
        put_rex_modrm(X86_MOV_ST, it.src, it.dst, 1'b1, 1'b1);
        put_le(it.value, 4);
      end
      OP_JMP_REL: begin
        enc_bytes.push_back(X86_JMP_REL);
        put_le(it.value, 4);
      end
      OP_LOAD: begin
        put_rex_modrm(X86_MOV_LD, it.dst, it.src, 1'b1, 1'b1);
        put_le(it.value, 4);
      end
      OP_PUSH:     put_short_reg(X86_PUSH, it.dst);
      OP_MOV_RR:   put_rex_modrm(X86_MOV_LD, it.dst, it.src, 1'b0, 1'b1);
      OP_SUB_IMM: begin
        put_rex_modrm(X86_GRP1_IMM, EXT_SUB, it.dst, 1'b0, 1'b1);
        put_le(it.value, 4);
      end
      OP_ADD_IMM: begin
        put_rex_modrm(X86_GRP1_IMM, EXT_ADD, it.dst, 1'b0, 1'b1);
        put_le(it.value, 4);
      end
      OP_POP:      put_short_reg(X86_POP, it.dst);
      OP_LEAVE:    enc_bytes.push_back(X86_LEAVE);
      OP_RET:      enc_bytes.push_back(X86_RET);
      OP_JMP_REG:  put_rex_modrm(X86_GRP5, EXT_JMP, it.dst, 1'b0, 1'b0);
      OP_JE_REL: begin
        enc_bytes.push_back(X86_ESC_0F);
        enc_bytes.push_back(X86_JE_REL);
        put_le(it.value, 4);
      end
      OP_OR_RR:    put_rex_modrm(X86_OR_RR, it.dst, it.src, 1'b0, 1'b1);
      OP_MOV_IMM64: begin
        enc_bytes.push_back(X86_REX_W | {7'b0, it.dst[3]});
        enc_bytes.push_back(X86_MOV_IMM + {5'b0, it.dst[2:0]});
        put_le(it.value, 8);
      end
      OP_CALL_REG: put_rex_modrm(X86_GRP5, EXT_CALL, it.dst, 1'b0, 1'b0);
      default: ;   // undefined form: nothing emitted, offset kept
    endcase
    for (int k = 0; k < enc_bytes.size(); k++) begin
      e = '{code_byte: enc_bytes[k], offset: code_offset, is_label: 1'b0,
            is_last: (k == enc_bytes.size() - 1)};
      bytes_expected.push_back(e);
      code_offset = code_offset + 32'd1;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  task automatic add_instr(logic restart, logic [4:0] op, logic [3:0] dst,
                           logic [3:0] src, logic [63:0] value);
    instr_pending.push_back('{quiesce: 1'b0, restart: restart, opcode: op,
                              dst: dst, src: src, value: value});
  endtask

  task automatic add_quiesce();
    instr_pending.push_back('{quiesce: 1'b1, default: '0});
  endtask

  initial begin
    int          pick;
    logic [4:0]  op;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [63:0] value;

    code_offset = '0;

    // Directed: every form at least once, SIB bases rsp/r12, REX.R/B extremes,
    // value extremes, undefined opcodes and restarts.
    add_instr(1'b1, OP_LABEL,     4'd0,  4'd0,  64'h0);
    add_instr(1'b0, OP_LEA,       4'd0,  4'd12, 64'h8000_0000_0000_0000);
    add_instr(1'b0, OP_STORE,     4'd4,  4'd15, 64'h7FFF_FFFF_FFFF_FFFF);
    add_instr(1'b0, OP_JMP_REL,   4'd9,  4'd3,  64'hFFFF_FFFF_FFFF_FFFF);
    add_instr(1'b0, OP_LOAD,      4'd15, 4'd4,  64'h0123_4567_89AB_CDEF);
    add_instr(1'b0, OP_PUSH,      4'd8,  4'd1,  64'h0);
    add_instr(1'b0, OP_PUSH,      4'd7,  4'd14, 64'h0);
    add_instr(1'b0, OP_MOV_RR,    4'd15, 4'd15, 64'h0);
    add_instr(1'b0, OP_SUB_IMM,   4'd12, 4'd0,  64'h0000_0000_8000_0000);
    add_instr(1'b0, OP_ADD_IMM,   4'd0,  4'd9,  64'hFFFF_FFFF_7FFF_FFFF);
    add_instr(1'b0, OP_POP,       4'd15, 4'd2,  64'h0);
    add_instr(1'b0, OP_POP,       4'd0,  4'd2,  64'h0);
    add_instr(1'b0, OP_LEAVE,     4'd5,  4'd6,  64'hAAAA_AAAA_AAAA_AAAA);
    add_instr(1'b0, OP_RET,       4'd10, 4'd11, 64'h5555_5555_5555_5555);
    add_instr(1'b0, OP_JMP_REG,   4'd12, 4'd3,  64'h0);
    add_instr(1'b0, OP_JE_REL,    4'd1,  4'd1,  64'h8000_0000_0000_0000);
    add_instr(1'b0, OP_OR_RR,     4'd8,  4'd7,  64'h0);
    add_instr(1'b0, OP_MOV_IMM64, 4'd15, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    add_instr(1'b0, OP_MOV_IMM64, 4'd0,  4'd15, 64'h8000_0000_0000_0001);
    add_instr(1'b0, OP_CALL_REG,  4'd8,  4'd0,  64'h0);
    add_instr(1'b0, OP_UNUSED_LO, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    add_instr(1'b1, OP_UNUSED_HI, 4'd3,  4'd3,  64'h0);
    add_instr(1'b0, OP_LABEL,     4'd0,  4'd0,  64'h0);   // offset still zero
    add_instr(1'b0, OP_LEAVE,     4'd0,  4'd0,  64'h0);
    add_instr(1'b1, OP_LABEL,     4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    add_quiesce();

    // Random program text: mostly real instructions, a few labels, restarts
    // and undefined opcodes mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else if (pick < 15)
        op = OP_LABEL;
      else
        op = 5'($urandom_range(OP_LEA, OP_CALL_REG));
      // rsp/r12 often, so SIB shows up in plenty of memory forms
      dst = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'd12 : 4'd4)
                                        : 4'($urandom_range(0, 15));
      src = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'd12 : 4'd4)
                                        : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
        0:       value = {1'b1, 63'h0};
        1:       value = {1'b0, {63{1'b1}}};
        2:       value = '1;
        default: value = {$urandom, $urandom};
      endcase
      add_instr(($urandom_range(0, 19) == 0), op, dst, src, value);
      if (n == RANDOM_ITEMS / 2)
        add_quiesce();
    end

    rst_n = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the sender's updates have settled
    while (instr_pending.size() != 0 || in_tvalid) @(negedge clk);
    while (bytes_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. Gaps are skipped
  // while the receiver holds off, so the queue inside the block fills and
  // in_tready drops. A quiesce marker parks the sender until every expected
  // byte has come out.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    bit offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_encoding(cur_instr);
        in_accepted <= in_accepted + 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = $urandom_range(1, 6);
        end
      end else if (in_tvalid) begin
        offer = 1'b1;   // not taken yet, hold the transaction
      end
      if (!offer) begin
        if (gap_left > 0 && !rcv_hold)
          gap_left = gap_left - 1;
        else if (instr_pending.size() != 0) begin
          if (instr_pending[0].quiesce) begin
            if (bytes_expected.size() == 0)
              instr_pending.delete(0);
          end else begin
            cur_instr = instr_pending.pop_front();
            offer     = 1'b1;
          end
        end
      end
      in_tvalid <= offer;
      in_tdata  <= {7'b0, cur_instr.value, cur_instr.src, cur_instr.dst,
                    cur_instr.restart};
      in_tuser  <= cur_instr.opcode;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: ready pattern is picked at random from the modes; one long hold-off once
  // enough transactions have gone in.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    bit rdy;
    rdy = 1'b1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_phase = rx_phase + 1;
      if (rx_phase % 50 == 0)
        rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (!hold_done && in_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:        rdy = 1'b1;
          RX_MOSTLY:        rdy = ($urandom_range(0, 3) != 0);
          RX_EVERY_4TH_LOW: rdy = (rx_phase % 4 != 3);
          default:          rdy = 1'($urandom_range(0, 1));
        endcase
      end
      rcv_hold   <= (hold_left > 0);
      out_tready <= rdy;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest expectation.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    emit_t want;
    emit_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{code_byte: out_tdata[7:0], offset: out_tdata[39:8],
              is_label: out_tuser, is_last: out_tlast};
      if (bytes_expected.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        $display("%0t: unexpected result byte=%h offset=%h label=%b last=%b",
                 $time, got.code_byte, got.offset, got.is_label, got.is_last);
      end else begin
        want = bytes_expected.pop_front();
        if (got.code_byte !== want.code_byte) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t: out_byte expected %h actual %h", $time,
                   want.code_byte, got.code_byte);
        end
        if (got.offset !== want.offset) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t: out_offset expected %h actual %h", $time,
                   want.offset, got.offset);
        end
        if (got.is_label !== want.is_label) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t: is_label expected %b actual %b", $time,
                   want.is_label, got.is_label);
        end
        if (got.is_last !== want.is_last) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t: is_last expected %b actual %b", $time,
                   want.is_last, got.is_last);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin : watchdog
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time,
               bytes_expected.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
